// ===== sv/sdpd_pkg.sv =====
// Shared types and constants for the SMS-DELIVER PDU decoder.
// No dependencies; imported by every module of the decoder.
package sdpd_pkg;

    typedef enum logic [2:0] {
        KIND_DIGIT    = 3'd0,
        KIND_TIME     = 3'd1,
        KIND_TEXT     = 3'd2,
        KIND_COMPLETE = 3'd3,
        KIND_ERROR    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        CFG_PHONE_CAPACITY = 2'd0,
        CFG_TEXT_CAPACITY  = 2'd1
    } cfg_reg_t;

    localparam int MAX_RESULTS = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [7:0] PHONE_CAPACITY_RESET = 8'd32;
    localparam logic [9:0] TEXT_CAPACITY_RESET  = 10'd512;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] position;
        logic [7:0] value;
        logic       final_res;
    } result_t;

    // One octet's worth of results, slot 0 goes out first
    typedef struct packed {
        logic [2:0]                    count;
        result_t [MAX_RESULTS-1:0]     res;
    } bundle_t;

endpackage

// ===== sv/sms_deliver_pdu_decoder_core.sv =====
// SMS-DELIVER PDU decoder top: sdpd_front, sdpd_queue and sdpd_back over sdpd_pkg.
// An accepted octet's first result is registered in the bundle queue, then in sdpd_back.
// Throughput one octet per cycle while the QueueDepth-entry bundle queue has room;
// results leave one per cycle when not stalled, so octets with several results
// (up to 4) and long septet runs (8 septets in 7 octets) throttle the input to it.
// Reset: asynchronous, active low; parser at frame start, capacities 32 / 512.
module sms_deliver_pdu_decoder_core #(
    parameter int QueueDepth = sdpd_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pdu_byte
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] position, [15:8] value
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast,   // final_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    import sdpd_pkg::*;

    bundle_t push_data;
    bundle_t pop_data;
    result_t out_res;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_not_empty;

    assign cfg_ready = 1'b1;

    sdpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (push_data)
    );

    sdpd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    sdpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {out_res.value, out_res.position};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.final_res;

endmodule

// ===== sv/sdpd_front.sv =====
// Front end: parses PDU octets and builds a bundle of results per octet.
// Holds the configuration registers. Depends on sdpd_pkg.
module sdpd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_index,
    input  logic [9:0]       cfg_data,
    input  logic             q_full,
    output logic             q_push,
    output sdpd_pkg::bundle_t q_data
);
    import sdpd_pkg::*;

    typedef enum logic [3:0] {
        PH_SCA_LEN = 4'd0,
        PH_SCA     = 4'd1,
        PH_FIRST   = 4'd2,
        PH_SLEN    = 4'd3,
        PH_TOA     = 4'd4,
        PH_DIG     = 4'd5,
        PH_PID     = 4'd6,
        PH_DCS     = 4'd7,
        PH_TS      = 4'd8,
        PH_UDL     = 4'd9,
        PH_TEXT    = 4'd10,
        PH_DONE    = 4'd11,
        PH_DISCARD = 4'd12
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] bc_reg, bc_next;
    logic [7:0] dt_reg, dt_next;
    logic [7:0] di_reg, di_next;
    logic [7:0] tl_reg, tl_next;
    logic [7:0] tc_reg, tc_next;
    logic [2:0] cb_reg, cb_next;
    logic [7:0] pb_reg, pb_next;
    logic [7:0] phone_cap_reg;
    logic [9:0] text_cap_reg;

    bundle_t    bnd;
    logic [2:0] n;
    logic       err_now;
    logic [2:0] c;
    logic [2:0] c_end;
    logic [15:0] pair;
    logic [7:0] lo_shift;
    logic       fire;

    function automatic result_t mk(kind_t k, logic [7:0] pos, logic [7:0] val);
        result_t r;
        r.kind      = k;
        r.position  = pos;
        r.value     = val;
        r.final_res = (k == KIND_COMPLETE) || (k == KIND_ERROR);
        return r;
    endfunction

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        phase_next = phase_reg;
        bc_next    = bc_reg;
        dt_next    = dt_reg;
        di_next    = di_reg;
        tl_next    = tl_reg;
        tc_next    = tc_reg;
        cb_next    = cb_reg;
        pb_next    = pb_reg;
        bnd        = '0;
        n          = 3'd0;
        err_now    = 1'b0;
        c          = (cb_reg == 3'd0) ? 3'd1 : cb_reg;
        pair       = {in_byte, pb_reg} >> (4'd8 - {1'b0, c});
        c_end      = 3'd1;
        lo_shift   = 8'd0;

        case (phase_reg)
            PH_SCA_LEN:
            begin
                bc_next    = in_byte;
                phase_next = (in_byte != 8'd0) ? PH_SCA : PH_FIRST;
            end
            PH_SCA:
            begin
                bc_next = bc_reg - 8'd1;
                if (bc_next == 8'd0)
                    phase_next = PH_FIRST;
            end
            PH_FIRST:
            begin
                if (!in_byte[2])
                    err_now = 1'b1;
                else
                    phase_next = PH_SLEN;
            end
            PH_SLEN:
            begin
                if ({1'b0, in_byte} + 9'd1 > {1'b0, phone_cap_reg})
                    err_now = 1'b1;
                else
                begin
                    dt_next    = in_byte;
                    di_next    = 8'd0;
                    phase_next = PH_TOA;
                end
            end
            PH_TOA:
                phase_next = (dt_reg != 8'd0) ? PH_DIG : PH_PID;
            PH_DIG:
            begin
                bnd.res[n[1:0]] = mk(KIND_DIGIT, di_next, {4'd0, in_byte[3:0]} + 8'h30);
                n       = n + 3'd1;
                di_next = di_next + 8'd1;
                if (di_next < dt_reg)
                begin
                    bnd.res[n[1:0]] = mk(KIND_DIGIT, di_next,
                                         {4'd0, in_byte[7:4]} + 8'h30);
                    n       = n + 3'd1;
                    di_next = di_next + 8'd1;
                end
                if (di_next >= dt_reg)
                    phase_next = PH_PID;
            end
            PH_PID:
                phase_next = PH_DCS;
            PH_DCS:
            begin
                bc_next    = 8'd0;
                phase_next = PH_TS;
            end
            PH_TS:
            begin
                // high nibble plus ten times low nibble
                bnd.res[n[1:0]] = mk(KIND_TIME, bc_reg,
                                     {4'd0, in_byte[7:4]} + {1'b0, in_byte[3:0], 3'b000}
                                     + {3'b000, in_byte[3:0], 1'b0});
                n       = n + 3'd1;
                bc_next = bc_reg + 8'd1;
                if (bc_next >= 8'd7)
                    phase_next = PH_UDL;
            end
            PH_UDL:
            begin
                tl_next = in_byte;
                if ({2'b00, in_byte} > text_cap_reg)
                    err_now = 1'b1;
                else
                begin
                    tc_next    = 8'd0;
                    bc_next    = 8'd0;
                    cb_next    = 3'd1;
                    phase_next = (in_byte != 8'd0) ? PH_TEXT : PH_DONE;
                end
            end
            PH_TEXT:
            begin
                if (bc_reg == 8'd0)
                begin
                    bnd.res[n[1:0]] = mk(KIND_TEXT, tc_next, {1'b0, in_byte[6:0]});
                    n       = n + 3'd1;
                    tc_next = tc_next + 8'd1;
                    if (tc_next == tl_reg)
                        phase_next = PH_DONE;
                end
                else
                begin
                    bnd.res[n[1:0]] = mk(KIND_TEXT, tc_next, {1'b0, pair[6:0]});
                    n       = n + 3'd1;
                    tc_next = tc_next + 8'd1;
                    if (tc_next == tl_reg)
                        phase_next = PH_DONE;
                    if (phase_next == PH_TEXT)
                    begin
                        // seven octets carry eight septets
                        if (c == 3'd7)
                        begin
                            c = 3'd1;
                            bnd.res[n[1:0]] = mk(KIND_TEXT, tc_next,
                                                 {1'b0, in_byte[6:0]});
                            n       = n + 3'd1;
                            tc_next = tc_next + 8'd1;
                            if (tc_next == tl_reg)
                                phase_next = PH_DONE;
                        end
                        else
                            c = c + 3'd1;
                    end
                end
                cb_next = c;
                pb_next = in_byte;
                bc_next = bc_reg + 8'd1;
            end
            default:
            begin
            end
        endcase

        if (err_now)
        begin
            bnd.res[n[1:0]] = mk(KIND_ERROR, 8'd0, 8'd0);
            n          = n + 3'd1;
            phase_next = PH_DISCARD;
        end

        if (in_last)
        begin
            if (phase_next == PH_DONE)
            begin
                bnd.res[n[1:0]] = mk(KIND_COMPLETE, 8'd0, 8'd0);
                n = n + 3'd1;
            end
            else if (phase_next == PH_TEXT)
            begin
                c_end    = (cb_next == 3'd0) ? 3'd1 : cb_next;
                lo_shift = pb_next >> (4'd8 - {1'b0, c_end});
                // leftover septet in the high bits of the last octet
                if (bc_next != 8'd0 && tc_next < tl_next)
                begin
                    bnd.res[n[1:0]] = mk(KIND_TEXT, tc_next, {1'b0, lo_shift[6:0]});
                    n       = n + 3'd1;
                    tc_next = tc_next + 8'd1;
                    if (tc_next == tl_next)
                        phase_next = PH_DONE;
                end
                bnd.res[n[1:0]] = mk((phase_next == PH_DONE) ? KIND_COMPLETE : KIND_ERROR,
                                     8'd0, 8'd0);
                n = n + 3'd1;
            end
            else if (phase_next != PH_DISCARD)
            begin
                bnd.res[n[1:0]] = mk(KIND_ERROR, 8'd0, 8'd0);
                n = n + 3'd1;
            end
            phase_next = PH_SCA_LEN;
            bc_next    = 8'd0;
            dt_next    = 8'd0;
            di_next    = 8'd0;
            tl_next    = 8'd0;
            tc_next    = 8'd0;
            cb_next    = 3'd1;
            pb_next    = 8'd0;
        end
        bnd.count = n;
    end

    assign q_push = fire && (n != 3'd0);
    assign q_data = bnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SCA_LEN;
            bc_reg    <= 8'd0;
            dt_reg    <= 8'd0;
            di_reg    <= 8'd0;
            tl_reg    <= 8'd0;
            tc_reg    <= 8'd0;
            cb_reg    <= 3'd1;
            pb_reg    <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            bc_reg    <= bc_next;
            dt_reg    <= dt_next;
            di_reg    <= di_next;
            tl_reg    <= tl_next;
            tc_reg    <= tc_next;
            cb_reg    <= cb_next;
            pb_reg    <= pb_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phone_cap_reg <= PHONE_CAPACITY_RESET;
            text_cap_reg  <= TEXT_CAPACITY_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_PHONE_CAPACITY)
                phone_cap_reg <= cfg_data[7:0];
            else if (cfg_index == CFG_TEXT_CAPACITY)
                text_cap_reg <= cfg_data;
        end
    end

    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_last |=> phase_reg == PH_SCA_LEN && cb_reg == 3'd1 && tc_reg == 8'd0)
        else $error("frame state not cleared after frame end");

    a_carry_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cb_reg != 3'd0)
        else $error("septet carry count left its range");

endmodule

// ===== sv/sdpd_queue.sv =====
// Short queue of result bundles between the parser and the output stage.
// Depends on sdpd_pkg.
module sdpd_queue #(
    parameter int Depth = sdpd_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sdpd_pkg::bundle_t push_data,
    input  logic              pop,
    output sdpd_pkg::bundle_t pop_data,
    output logic              full,
    output logic              not_empty
);
    import sdpd_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    bundle_t          mem_reg [Depth];
    logic [PtrW-1:0]  wr_reg, wr_next;
    logic [PtrW-1:0]  rd_reg, rd_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (cnt_reg == CntW'(Depth));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == PtrW'(Depth - 1)) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == PtrW'(Depth - 1)) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("bundle pushed into a full queue");

endmodule

// ===== sv/sdpd_back.sv =====
// Output stage: sends queued bundles' results one per cycle while out_ready holds.
// Depends on sdpd_pkg.
module sdpd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  sdpd_pkg::bundle_t q_data,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output sdpd_pkg::result_t out_res
);
    import sdpd_pkg::*;

    bundle_t    cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic       last;
    logic       advance;

    assign last      = ({1'b0, idx_reg} + 3'd1) == cur_reg.count;
    assign advance   = !valid_reg || (out_ready && last);
    assign q_pop     = advance && q_valid;
    assign out_valid = valid_reg;
    assign out_res   = cur_reg.res[idx_reg];

    always_comb
    begin
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = q_valid;
            cur_next   = q_data;
            idx_next   = 2'd0;
        end
        else if (out_ready)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    a_slot_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> cur_reg.count != 3'd0 && {1'b0, idx_reg} < cur_reg.count)
        else $error("output slot outside the current bundle");

endmodule

// ===== bench/sdpd_checker.sv =====
// Result checker for the SMS-DELIVER PDU decoder: predicts every result from the
// accepted octets and register writes, and compares the output stream against it.
// Depends on sdpd_pkg.
module sdpd_checker
    import sdpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    output int          fail_count,
    output int          outstanding,
    output int          checked_count,
    output int          error_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] ASCII_ZERO = 8'h30;

    typedef enum logic [3:0] {
        P_SCA_LEN,
        P_SCA_SKIP,
        P_FIRST,
        P_SENDER_LEN,
        P_ADDR_TYPE,
        P_DIGITS,
        P_PID,
        P_DCS,
        P_STAMP,
        P_UD_LEN,
        P_TEXT,
        P_DONE,
        P_DISCARD
    } parse_phase_t;

    logic [7:0]   phone_cap;
    logic [9:0]   text_cap;
    parse_phase_t phase;
    logic [7:0]   octet_cnt;
    logic [7:0]   digit_total;
    logic [7:0]   digit_idx;
    logic [7:0]   text_len;
    logic [7:0]   text_cnt;
    logic [7:0]   prev_octet;
    int           carry;
    result_t      expected_results[$];

    task automatic clear_frame();
        phase       = P_SCA_LEN;
        octet_cnt   = 8'd0;
        digit_total = 8'd0;
        digit_idx   = 8'd0;
        text_len    = 8'd0;
        text_cnt    = 8'd0;
        carry       = 1;
        prev_octet  = 8'd0;
    endtask

    task automatic push_result(input kind_t k, input logic [7:0] pos, input logic [7:0] val);
        result_t r;
        r.kind      = k;
        r.position  = pos;
        r.value     = val;
        r.final_res = (k == KIND_COMPLETE || k == KIND_ERROR);
        expected_results.push_back(r);
    endtask

    task automatic emit_septet(input logic [7:0] code);
        push_result(KIND_TEXT, text_cnt, code & 8'h7F);
        text_cnt = text_cnt + 8'd1;
        if (text_cnt == text_len)
            phase = P_DONE;
    endtask

    // 7-bit unpacking; the eighth octet of a group yields two septets
    task automatic take_text_octet(input logic [7:0] b);
        int c;
        c = carry;
        if (c < 1 || c > 7)
            c = 1;
        if (octet_cnt == 8'd0)
            emit_septet(b);
        else
        begin
            emit_septet(8'((b << c) | (prev_octet >> (8 - c))));
            if (phase == P_TEXT)
            begin
                c++;
                if (c == 8)
                begin
                    c = 1;
                    emit_septet(b);
                end
            end
        end
        carry      = c;
        prev_octet = b;
        octet_cnt  = octet_cnt + 8'd1;
    endtask

    task automatic decode_octet(input logic [7:0] b, input logic fin);
        logic reject;
        int   c;
        reject = 1'b0;
        case (phase)
            P_SCA_LEN:
            begin
                octet_cnt = b;
                phase = (b != 8'd0) ? P_SCA_SKIP : P_FIRST;
            end
            P_SCA_SKIP:
            begin
                octet_cnt = octet_cnt - 8'd1;
                if (octet_cnt == 8'd0)
                    phase = P_FIRST;
            end
            P_FIRST:
                if (b[2])
                    phase = P_SENDER_LEN;
                else
                    reject = 1'b1;
            P_SENDER_LEN:
                if (int'(b) + 1 > int'(phone_cap))
                    reject = 1'b1;
                else
                begin
                    digit_total = b;
                    digit_idx   = 8'd0;
                    phase       = P_ADDR_TYPE;
                end
            P_ADDR_TYPE:
                phase = (digit_total != 8'd0) ? P_DIGITS : P_PID;
            P_DIGITS:
            begin
                push_result(KIND_DIGIT, digit_idx, {4'd0, b[3:0]} + ASCII_ZERO);
                digit_idx = digit_idx + 8'd1;
                if (digit_idx < digit_total)
                begin
                    push_result(KIND_DIGIT, digit_idx, {4'd0, b[7:4]} + ASCII_ZERO);
                    digit_idx = digit_idx + 8'd1;
                end
                if (digit_idx >= digit_total)
                    phase = P_PID;
            end
            P_PID:
                phase = P_DCS;
            P_DCS:
            begin
                octet_cnt = 8'd0;
                phase     = P_STAMP;
            end
            P_STAMP:
            begin
                push_result(KIND_TIME, octet_cnt, 8'(b[7:4] + b[3:0] * 10));
                octet_cnt = octet_cnt + 8'd1;
                if (octet_cnt >= 8'd7)
                    phase = P_UD_LEN;
            end
            P_UD_LEN:
            begin
                text_len = b;
                if ({2'b00, b} > text_cap)
                    reject = 1'b1;
                else
                begin
                    text_cnt  = 8'd0;
                    octet_cnt = 8'd0;
                    carry     = 1;
                    phase     = (b != 8'd0) ? P_TEXT : P_DONE;
                end
            end
            P_TEXT:
                take_text_octet(b);
            default:
                ;
        endcase

        if (reject)
        begin
            push_result(KIND_ERROR, 8'd0, 8'd0);
            phase = P_DISCARD;
        end

        if (fin)
        begin
            if (phase == P_DONE)
                push_result(KIND_COMPLETE, 8'd0, 8'd0);
            else if (phase == P_TEXT)
            begin
                // leftover septet only once some text octet has arrived
                c = carry;
                if (c < 1 || c > 7)
                    c = 1;
                if (octet_cnt > 8'd0 && text_cnt < text_len)
                    emit_septet(prev_octet >> (8 - c));
                push_result((phase == P_DONE) ? KIND_COMPLETE : KIND_ERROR, 8'd0, 8'd0);
            end
            else if (phase != P_DISCARD)
                push_result(KIND_ERROR, 8'd0, 8'd0);
            clear_frame();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            phone_cap = PHONE_CAPACITY_RESET;
            text_cap  = TEXT_CAPACITY_RESET;
            clear_frame();
            expected_results.delete();
            fail_count    <= 0;
            outstanding   <= 0;
            checked_count <= 0;
            error_results <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_reg_t'(cfg_index))
                    CFG_PHONE_CAPACITY: phone_cap = cfg_data[7:0];
                    CFG_TEXT_CAPACITY:  text_cap  = cfg_data;
                    default:            ;
                endcase

            if (s_axis_tvalid && s_axis_tready)
                decode_octet(s_axis_tdata, s_axis_tlast);

            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind      = kind_t'(m_axis_tuser);
                got.position  = m_axis_tdata[7:0];
                got.value     = m_axis_tdata[15:8];
                got.final_res = m_axis_tlast;
                checked_count <= checked_count + 1;
                if (got.kind == KIND_ERROR)
                    error_results <= error_results + 1;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d position=%0d value=%0d final=%0b",
                             $time, got.kind, got.position, got.value, got.final_res);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.position !== want.position ||
                        got.value !== want.value || got.final_res !== want.final_res)
                    begin
                        $display("%0t: mismatch, expected kind=%0d position=%0d value=%0d final=%0b",
                                 $time, want.kind, want.position, want.value, want.final_res);
                        $display("%0t:           actual kind=%0d position=%0d value=%0d final=%0b",
                                 $time, got.kind, got.position, got.value, got.final_res);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

// ===== bench/tb_sms_deliver_pdu_decoder_core.sv =====
// Testbench top for sms_deliver_pdu_decoder_core: drives PDU octets and register
// writes with random idling, and gives the verdict. Depends on sdpd_pkg, sdpd_checker.
module tb_sms_deliver_pdu_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;
    import sdpd_pkg::*;

    localparam int DRAIN_CYCLES = 8;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [9:0]  cfg_data;

    int fail_count;
    int outstanding;
    int checked_count;
    int error_results;

    bit         steady;
    bit         noise_pdu;
    logic [7:0] pdu[$];
    int         pdus_sent;
    int         octets_sent;
    int         settings_used;

    sms_deliver_pdu_decoder_core i_dut (.*);

    sdpd_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("sms_deliver_pdu_decoder_core test failed");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 11);
        end
    end

    task automatic send_octet(input logic [7:0] b, input logic fin);
        while (!steady && $urandom_range(0, 99) < 11)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        octets_sent++;
    endtask

    task automatic send_pdu();
        foreach (pdu[i])
            send_octet(pdu[i], i == pdu.size() - 1);
        pdus_sent++;
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [9:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // hold the sender until every predicted result is out, then let the pipe drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Mostly well-formed PDUs with random content; the rest are noise, bad first
    // octets, over-capacity lengths, truncated frames and surplus tails.
    task automatic build_random_pdu(input int phone_cap, input int text_cap);
        int         style;
        int         sca;
        int         slen;
        int         max_slen;
        int         udl;
        int         max_udl;
        int         cut;
        logic [7:0] octet;
        pdu.delete();
        noise_pdu = 1'b0;
        style = $urandom_range(0, 99);
        if (style < 6)
        begin
            noise_pdu = 1'b1;
            repeat ($urandom_range(1, 6)) pdu.push_back(8'($urandom));
            return;
        end
        sca = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 12) : $urandom_range(0, 2);
        pdu.push_back(8'(sca));
        repeat (sca) pdu.push_back(8'($urandom));
        octet = 8'($urandom);
        octet[2] = (style >= 10);
        pdu.push_back(octet);
        if (style < 10)
        begin
            repeat ($urandom_range(0, 3)) pdu.push_back(8'($urandom));
            return;
        end

        max_slen = phone_cap - 1;
        if (style < 15 || max_slen < 0)
            slen = $urandom_range(phone_cap, 255);
        else if ($urandom_range(0, 49) == 0)
            slen = max_slen;
        else
            slen = $urandom_range(0, (max_slen < 20) ? max_slen : 20);
        pdu.push_back(8'(slen));
        if (slen > max_slen)
        begin
            repeat ($urandom_range(0, 3)) pdu.push_back(8'($urandom));
            return;
        end
        // address type, digits, PID, DCS and the seven timestamp octets
        repeat ((slen + 1) / 2 + 10) pdu.push_back(8'($urandom));

        max_udl = (text_cap < 255) ? text_cap : 255;
        if (style < 20 && max_udl < 255)
        begin
            pdu.push_back(8'($urandom_range(max_udl + 1, 255)));
            repeat ($urandom_range(0, 3)) pdu.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(0, 9) == 0)
            udl = 0;
        else if ($urandom_range(0, 29) == 0)
            udl = max_udl;
        else
            udl = $urandom_range(0, (max_udl < 40) ? max_udl : 40);
        pdu.push_back(8'(udl));
        repeat ((udl * 7 + 7) / 8) pdu.push_back(8'($urandom));

        if (style < 30 && pdu.size() > 1)
        begin
            cut = $urandom_range(1, pdu.size() - 1);
            while (pdu.size() > cut)
                void'(pdu.pop_back());
        end
        else if (style < 40)
            repeat ($urandom_range(1, 4)) pdu.push_back(8'($urandom));
    endtask

    task automatic run_random_phase(input int phone_cap, input int text_cap,
                                    input int budget, input bit calm);
        int done_octets;
        settle();
        cfg_write(CFG_PHONE_CAPACITY, 10'(phone_cap));
        cfg_write(CFG_TEXT_CAPACITY, 10'(text_cap));
        settings_used++;
        steady = calm;
        done_octets = 0;
        while (done_octets < budget)
        begin
            build_random_pdu(phone_cap, text_cap);
            if (!noise_pdu)
                done_octets += pdu.size();
            send_pdu();
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_PHONE_CAPACITY;
        cfg_data      = 10'd0;
        steady        = 1'b0;
        noise_pdu     = 1'b0;
        pdus_sent     = 0;
        octets_sent   = 0;
        settings_used = 1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        cfg_write(CFG_PHONE_CAPACITY, 10'd255);
        cfg_write(CFG_TEXT_CAPACITY, 10'd512);

        // first octet without bit 2
        pdu = '{8'h00, 8'h00};
        send_pdu();
        // 255 sender digits exceed any capacity
        pdu = '{8'h00, 8'h04, 8'hFF};
        send_pdu();
        // frame ends right after the first octet
        pdu = '{8'h01, 8'hFF, 8'h04};
        send_pdu();
        // full PDU: odd digit count, extreme timestamp octets, leftover septet
        pdu = '{8'h00, 8'hFF, 8'h03, 8'h91, 8'h21, 8'hF3, 8'h00, 8'h00,
                8'h00, 8'hFF, 8'h99, 8'h12, 8'h34, 8'h56, 8'h7A, 8'h08,
                8'hFF, 8'h00, 8'hAA, 8'h55, 8'h01, 8'h80, 8'h7F};
        send_pdu();

        run_random_phase(255, 512, 50, 1'b0);
        run_random_phase(1, 0, 25, 1'b0);
        run_random_phase($urandom_range(2, 40), $urandom_range(0, 60), 50, 1'b0);
        run_random_phase(32, 300, 50, 1'b1);
        run_random_phase(0, 512, 15, 1'b0);
        run_random_phase($urandom_range(1, 255), $urandom_range(0, 512), 50, 1'b0);

        settle();
        $display("Sent %0d PDUs (%0d octets) under %0d capacity settings;", pdus_sent,
                 octets_sent, settings_used);
        $display("checked %0d results, %0d of them error results.", checked_count,
                 error_results);
        if (fail_count == 0)
            $display("sms_deliver_pdu_decoder_core test passed");
        else
            $display("sms_deliver_pdu_decoder_core test failed");
        $finish;
    end

endmodule
